FILE: sv/drg_pkg.sv
// Package for the depth region grow block: codes, reset values and the
// command and status types between controller and datapath. No dependencies.
package drg_pkg;

    localparam int IDX_W   = 18;
    localparam int DVAL_W  = 16;
    localparam int SEED_W  = 9;
    localparam int COUNT_W = 19;
    localparam int STAT_W  = 2;
    localparam int CFG_W   = 10;
    localparam int THR_W   = 16;
    localparam int CIDX_W  = 2;
    localparam int CDAT_W  = 16;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_GROW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_THRESH = 2'd2;

    localparam logic [CFG_W-1:0] RST_WIDTH  = 10'd512;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 10'd424;
    localparam logic [THR_W-1:0] RST_THRESH = 16'd50;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // Neighbor visiting order.
    localparam logic [2:0] NB_RIGHT = 3'd0;
    localparam logic [2:0] NB_DOWN  = 3'd1;
    localparam logic [2:0] NB_LEFT  = 3'd2;
    localparam logic [2:0] NB_UP    = 3'd3;
    localparam logic [2:0] NB_DR    = 3'd4;
    localparam logic [2:0] NB_UR    = 3'd5;
    localparam logic [2:0] NB_DL    = 3'd6;
    localparam logic [2:0] NB_UL    = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_CLEAR, S_SEED, S_SEEDRD, S_SEEDCHK, S_POP,
        S_NBADDR, S_NBRD, S_NBCHK, S_RDWAIT, S_RDOUT
    } t_state;

    typedef enum logic [2:0] {
        RES_OK, RES_RANGE, RES_ZERO, RES_MASK, RES_COUNT
    } t_res_sel;

    typedef struct packed {
        logic     load;
        logic     depth_wr;
        logic     clr_step;
        logic     addr_pix;
        logic     addr_seed;
        logic     addr_nb;
        logic     seed_init;
        logic     pop;
        logic     nb_next;
        logic     join_px;
        logic     emit;
        t_res_sel res_sel;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       in_range;
        logic       clr_last;
        logic       seed_out;
        logic       seed_zero;
        logic       q_empty;
        logic       nb_valid;
        logic       nb_last;
        logic       join_ok;
    } t_sts;

endpackage

FILE: sv/drg_ctrl.sv
// Controller state machine of the depth region grow block.
// Depends on drg_pkg; drives the datapath through t_cmd and reads t_sts.
module drg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  drg_pkg::t_sts i_sts,
    output drg_pkg::t_cmd o_cmd
);
    import drg_pkg::*;

    t_state r_state, n_state;
    logic   r_grow, n_grow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_grow  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_grow  <= n_grow;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_grow  = r_grow;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                case (i_sts.op)
                    OP_WRITE: begin
                        o_cmd.emit = 1'b1;
                        if (i_sts.in_range) begin
                            o_cmd.depth_wr = 1'b1;
                            o_cmd.res_sel  = RES_OK;
                        end else begin
                            o_cmd.res_sel = RES_RANGE;
                        end
                    end
                    OP_GROW: begin
                        n_grow  = 1'b1;
                        n_state = S_CLEAR;
                    end
                    OP_READ: begin
                        if (i_sts.in_range) begin
                            o_cmd.addr_pix = 1'b1;
                            n_state        = S_RDWAIT;
                        end else begin
                            o_cmd.emit    = 1'b1;
                            o_cmd.res_sel = RES_RANGE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = r_grow ? S_SEED : S_IDLE;
                end
            end
            S_SEED: begin
                n_grow = 1'b0;
                if (i_sts.seed_out) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.res_sel = RES_RANGE;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.addr_seed = 1'b1;
                    n_state         = S_SEEDRD;
                end
            end
            S_SEEDRD: n_state = S_SEEDCHK;
            S_SEEDCHK: begin
                if (i_sts.seed_zero) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.res_sel = RES_ZERO;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.seed_init = 1'b1;
                    n_state         = S_POP;
                end
            end
            S_POP: begin
                if (i_sts.q_empty) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.res_sel = RES_COUNT;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_NBADDR;
                end
            end
            S_NBADDR: begin
                if (i_sts.nb_valid) begin
                    o_cmd.addr_nb = 1'b1;
                    n_state       = S_NBRD;
                end else if (i_sts.nb_last) begin
                    n_state = S_POP;
                end else begin
                    o_cmd.nb_next = 1'b1;
                end
            end
            S_NBRD: n_state = S_NBCHK;
            S_NBCHK: begin
                o_cmd.join_px = i_sts.join_ok;
                if (i_sts.nb_last) begin
                    n_state = S_POP;
                end else begin
                    o_cmd.nb_next = 1'b1;
                    n_state       = S_NBADDR;
                end
            end
            S_RDWAIT: n_state = S_RDOUT;
            S_RDOUT: begin
                o_cmd.emit    = 1'b1;
                o_cmd.res_sel = RES_MASK;
                n_state       = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_emit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == S_IDLE))
        else $error("result emitted without returning to idle");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_DECODE))
        else $error("accepted item not decoded");

    a_check_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NBCHK) |-> ($past(r_state) == S_NBRD))
        else $error("neighbor check without memory read");

endmodule

FILE: sv/drg_dpath.sv
// Datapath of the depth region grow block: configuration registers, depth,
// mask and queue memories, address arithmetic and result registers. Uses drg_pkg.
module drg_dpath #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int DEPTH_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [drg_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [drg_pkg::CDAT_W-1:0]    i_cfg_data,
    input  logic [1:0]                    i_op,
    input  logic [drg_pkg::IDX_W-1:0]     i_pixel_index,
    input  logic [drg_pkg::DVAL_W-1:0]    i_depth_value,
    input  logic [drg_pkg::SEED_W-1:0]    i_seed_col,
    input  logic [drg_pkg::SEED_W-1:0]    i_seed_row,
    input  drg_pkg::t_cmd                 i_cmd,
    output drg_pkg::t_sts                 o_sts,
    output logic                          o_done,
    output logic                          o_mask_bit,
    output logic [drg_pkg::COUNT_W-1:0]   o_pixel_count,
    output logic [drg_pkg::STAT_W-1:0]    o_status
);
    import drg_pkg::*;

    localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(STORE);
    localparam int CB    = $clog2(MAX_WIDTH);
    localparam int RB    = $clog2(MAX_HEIGHT);
    localparam int XW    = $clog2(MAX_WIDTH + 1);
    localparam int YW    = $clog2(MAX_HEIGHT + 1);
    localparam int QW    = RB + CB;
    localparam int LW    = AW + 1;

    logic [DEPTH_BITS-1:0] r_depth_mem [STORE];
    logic                  r_mask_mem  [STORE];
    logic [QW-1:0]         r_queue_mem [STORE];

    logic [CFG_W-1:0]      r_cfg_w, r_cfg_h;
    logic [THR_W-1:0]      r_thr;
    logic [1:0]            r_op;
    logic [IDX_W-1:0]      r_pix;
    logic [DEPTH_BITS-1:0] r_dval;
    logic [SEED_W-1:0]     r_sc, r_sr;

    logic [AW-1:0]         r_addr, r_clr;
    logic [LW-1:0]         r_head, r_tail;
    logic [COUNT_W-1:0]    r_cnt;
    logic [2:0]            r_k;
    logic [QW-1:0]         r_cur;
    logic [RB-1:0]         r_nr;
    logic [CB-1:0]         r_nc;
    logic [DEPTH_BITS-1:0] r_seed_depth, r_rd_depth;
    logic                  r_rd_mask;

    logic [XW-1:0]         eff_w;
    logic [YW-1:0]         eff_h;
    logic [LW-1:0]         limit;
    logic [RB-1:0]         cur_r, nr;
    logic [CB-1:0]         cur_c, nc;
    logic                  rt, lf, dn, up, nb_ok;
    logic [AW-1:0]         seed_idx, nb_idx;
    logic [DEPTH_BITS-1:0] diff;
    logic                  res_mask;
    logic [COUNT_W-1:0]    res_count;
    logic [STAT_W-1:0]     res_status;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RST_WIDTH;
            r_cfg_h <= RST_HEIGHT;
            r_thr   <= RST_THRESH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_cfg_w <= i_cfg_data[CFG_W-1:0];
                CFG_HEIGHT: r_cfg_h <= i_cfg_data[CFG_W-1:0];
                CFG_THRESH: r_thr   <= i_cfg_data[THR_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_w == '0) begin
            eff_w = XW'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            eff_w = XW'(MAX_WIDTH);
        end else begin
            eff_w = XW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            eff_h = YW'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            eff_h = YW'(MAX_HEIGHT);
        end else begin
            eff_h = YW'(r_cfg_h);
        end
    end

    assign limit = LW'(eff_w) * LW'(eff_h);

    // Neighbor geometry of the pixel being expanded.
    assign cur_r = r_cur[QW-1:CB];
    assign cur_c = r_cur[CB-1:0];
    assign rt    = (XW'(cur_c) + XW'(1)) < eff_w;
    assign lf    = (cur_c != '0);
    assign dn    = (YW'(cur_r) + YW'(1)) < eff_h;
    assign up    = (cur_r != '0);

    always_comb begin
        nr    = cur_r;
        nc    = cur_c;
        nb_ok = 1'b0;
        case (r_k)
            NB_RIGHT: begin nc = cur_c + CB'(1); nb_ok = rt; end
            NB_DOWN:  begin nr = cur_r + RB'(1); nb_ok = dn; end
            NB_LEFT:  begin nc = cur_c - CB'(1); nb_ok = lf; end
            NB_UP:    begin nr = cur_r - RB'(1); nb_ok = up; end
            NB_DR: begin
                nr = cur_r + RB'(1); nc = cur_c + CB'(1); nb_ok = rt && dn;
            end
            NB_UR: begin
                nr = cur_r - RB'(1); nc = cur_c + CB'(1); nb_ok = rt && up;
            end
            NB_DL: begin
                nr = cur_r + RB'(1); nc = cur_c - CB'(1); nb_ok = lf && dn;
            end
            NB_UL: begin
                nr = cur_r - RB'(1); nc = cur_c - CB'(1); nb_ok = lf && up;
            end
            default: nb_ok = 1'b0;
        endcase
    end

    assign seed_idx = AW'(r_sr) * AW'(eff_w) + AW'(r_sc);
    assign nb_idx   = AW'(nr) * AW'(eff_w) + AW'(nc);
    assign diff     = (r_seed_depth > r_rd_depth) ? (r_seed_depth - r_rd_depth)
                                                  : (r_rd_depth - r_seed_depth);

    always_comb begin
        o_sts           = '0;
        o_sts.op        = r_op;
        o_sts.in_range  = 32'(r_pix) < 32'(limit);
        o_sts.clr_last  = &r_clr;
        o_sts.seed_out  = (32'(r_sc) >= 32'(eff_w)) || (32'(r_sr) >= 32'(eff_h));
        o_sts.seed_zero = (r_rd_depth == '0);
        o_sts.q_empty   = (r_head == r_tail);
        o_sts.nb_valid  = nb_ok;
        o_sts.nb_last   = (r_k == NB_UL);
        o_sts.join_ok   = !r_rd_mask && (32'(diff) <= 32'(r_thr));
    end

    // Latched item fields and working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_pix  <= i_pixel_index;
            r_dval <= DEPTH_BITS'(i_depth_value);
            r_sc   <= i_seed_col;
            r_sr   <= i_seed_row;
        end
        if (i_cmd.addr_pix) begin
            r_addr <= AW'(r_pix);
        end else if (i_cmd.addr_seed) begin
            r_addr <= seed_idx;
        end else if (i_cmd.addr_nb) begin
            r_addr <= nb_idx;
            r_nr   <= nr;
            r_nc   <= nc;
        end
        if (i_cmd.seed_init) begin
            r_seed_depth <= r_rd_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
            r_k    <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.seed_init) begin
                r_head <= '0;
                r_tail <= LW'(1);
                r_cnt  <= COUNT_W'(1);
            end else if (i_cmd.join_px) begin
                r_tail <= r_tail + LW'(1);
                r_cnt  <= r_cnt + COUNT_W'(1);
            end
            if (i_cmd.pop) begin
                r_head <= r_head + LW'(1);
                r_k    <= '0;
            end else if (i_cmd.nb_next) begin
                r_k <= r_k + 3'd1;
            end
        end
    end

    // Depth store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.depth_wr) begin
            r_depth_mem[AW'(r_pix)] <= r_dval;
        end
        r_rd_depth <= r_depth_mem[r_addr];
    end

    // Visited mask.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_mask_mem[r_clr] <= 1'b0;
        end else if (i_cmd.seed_init || i_cmd.join_px) begin
            r_mask_mem[r_addr] <= 1'b1;
        end
        r_rd_mask <= r_mask_mem[r_addr];
    end

    // Pending queue of (row, column) pairs.
    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_init) begin
            r_queue_mem[AW'(0)] <= {RB'(r_sr), CB'(r_sc)};
        end else if (i_cmd.join_px) begin
            r_queue_mem[r_tail[AW-1:0]] <= {r_nr, r_nc};
        end
        if (i_cmd.pop) begin
            r_cur <= r_queue_mem[r_head[AW-1:0]];
        end
    end

    // Result fields selected by the controller.
    always_comb begin
        res_mask   = 1'b0;
        res_count  = '0;
        res_status = ST_OK;
        case (i_cmd.res_sel)
            RES_RANGE: res_status = ST_RANGE;
            RES_ZERO:  res_status = ST_ZERO;
            RES_MASK:  res_mask   = r_rd_mask;
            RES_COUNT: res_count  = r_cnt;
            default:   res_status = ST_OK;
        endcase
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            o_mask_bit    <= res_mask;
            o_pixel_count <= res_count;
            o_status      <= res_status;
        end
    end

endmodule

FILE: sv/depth_region_grow_top.sv
// Top level of the depth region grow block: connects controller and datapath.
// Depends on drg_pkg, drg_ctrl and drg_dpath.
//
// A user loads a depth frame one pixel per item (op write), then starts a grow
// from a seed pixel (op grow), then reads mask bits back by raster index
// (op read). An item is taken at a clock edge where start is high and busy is
// low; the block then works on that item alone and drops busy when done. Each
// result appears for exactly one cycle with o_done high; the receiver cannot
// stall it, so it must capture it in that cycle. A write is decoded and its
// result registered; a read registers the pixel address, then the mask bit,
// then its result. A grow first sweeps the whole visited mask, one entry per
// cycle; the same sweep runs right after reset, while busy stays high. The
// flood itself then reads and checks the seed, and for every region pixel
// pops it from the queue and visits each of its eight neighbors (address,
// memory read, compare and update; a neighbor outside the frame ends at its
// address step). The user must write configuration registers through the
// i_cfg_ port only while busy is low; the block itself does not enforce this.
module depth_region_grow_top #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int DEPTH_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [drg_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [drg_pkg::CDAT_W-1:0]    i_cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_op,
    input  logic [drg_pkg::IDX_W-1:0]     i_pixel_index,
    input  logic [drg_pkg::DVAL_W-1:0]    i_depth_value,
    input  logic [drg_pkg::SEED_W-1:0]    i_seed_col,
    input  logic [drg_pkg::SEED_W-1:0]    i_seed_row,
    output logic                          o_done,
    output logic                          o_mask_bit,
    output logic [drg_pkg::COUNT_W-1:0]   o_pixel_count,
    output logic [drg_pkg::STAT_W-1:0]    o_status
);
    import drg_pkg::*;

    // Commands from the controller and status back from the datapath.
    t_cmd cmd;
    t_sts sts;

    drg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    drg_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_op          (i_op),
        .i_pixel_index (i_pixel_index),
        .i_depth_value (i_depth_value),
        .i_seed_col    (i_seed_col),
        .i_seed_row    (i_seed_row),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_done        (o_done),
        .o_mask_bit    (o_mask_bit),
        .o_pixel_count (o_pixel_count),
        .o_status      (o_status)
    );

endmodule

FILE: test/tb.sv
// Self-checking testbench for depth_region_grow_top: loads depth frames, runs
// region grows and reads mask bits back, checking every result against a predictor.
// Depends on drg_pkg and depth_region_grow_top.
module tb;
    import drg_pkg::*;

    localparam int STORE_N = 512 * 512;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // One grow sweeps the whole mask, so the limit is set by the handful of grows.
    localparam longint CYCLE_LIMIT = 8000000;

    typedef struct {
        logic                mask_bit;
        logic [COUNT_W-1:0]  pixel_count;
        logic [STAT_W-1:0]   status;
    } t_answer;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CIDX_W-1:0]    i_cfg_index;
    logic [CDAT_W-1:0]    i_cfg_data;
    logic                 start;
    logic                 busy;
    logic [1:0]           i_op;
    logic [IDX_W-1:0]     i_pixel_index;
    logic [DVAL_W-1:0]    i_depth_value;
    logic [SEED_W-1:0]    i_seed_col;
    logic [SEED_W-1:0]    i_seed_row;
    logic                 o_done;
    logic                 o_mask_bit;
    logic [COUNT_W-1:0]   o_pixel_count;
    logic [STAT_W-1:0]    o_status;

    depth_region_grow_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .start(start), .busy(busy), .i_op(i_op), .i_pixel_index(i_pixel_index),
        .i_depth_value(i_depth_value), .i_seed_col(i_seed_col),
        .i_seed_row(i_seed_row), .o_done(o_done), .o_mask_bit(o_mask_bit),
        .o_pixel_count(o_pixel_count), .o_status(o_status)
    );

    // Predictor state: its own copy of the depth frame, the grown region and
    // the three registers, as they stand after reset.
    bit [DVAL_W-1:0]  depth_mem [0:STORE_N-1];
    bit               region_mask [0:STORE_N-1];
    logic [CFG_W-1:0] reg_width  = RST_WIDTH;
    logic [CFG_W-1:0] reg_height = RST_HEIGHT;
    logic [THR_W-1:0] reg_thresh = RST_THRESH;

    t_answer awaited_answers [$];
    int      fail_count = 0;
    int      idle_pct = 0;
    longint  cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Register values of zero behave as one; values above the maximum clamp.
    function automatic int active_width();
        if (reg_width == 0) return 1;
        if (reg_width > 512) return 512;
        return int'(reg_width);
    endfunction

    function automatic int active_height();
        if (reg_height == 0) return 1;
        if (reg_height > 512) return 512;
        return int'(reg_height);
    endfunction

    // Breadth-first 8-connected flood from the seed. Visiting order does not
    // change the final region, so a plain queue of raster indices is enough.
    function automatic t_answer flood_region(int sc, int sr);
        t_answer ans;
        int w, h, seed_pos, pos, r, c, nr, nc, npos, diff;
        int frontier [$];
        int region_size;
        w = active_width();
        h = active_height();
        ans.mask_bit = 1'b0;
        ans.pixel_count = '0;
        foreach (region_mask[k]) region_mask[k] = 1'b0;
        if (sc >= w || sr >= h) begin
            ans.status = ST_RANGE;
            return ans;
        end
        seed_pos = sr * w + sc;
        if (depth_mem[seed_pos] == 0) begin
            ans.status = ST_ZERO;
            return ans;
        end
        region_mask[seed_pos] = 1'b1;
        frontier.insert(frontier.size(), seed_pos);
        region_size = 1;
        while (frontier.size() > 0) begin
            pos = frontier.pop_front();
            r = pos / w;
            c = pos % w;
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    nr = r + dr;
                    nc = c + dc;
                    if ((dr != 0 || dc != 0) && nr >= 0 && nr < h && nc >= 0 && nc < w) begin
                        npos = nr * w + nc;
                        diff = int'(depth_mem[npos]) - int'(depth_mem[seed_pos]);
                        if (diff < 0) diff = -diff;
                        if (!region_mask[npos] && diff <= int'(reg_thresh)) begin
                            region_mask[npos] = 1'b1;
                            frontier.insert(frontier.size(), npos);
                            region_size++;
                        end
                    end
                end
            end
        end
        ans.pixel_count = COUNT_W'(region_size);
        ans.status = ST_OK;
        return ans;
    endfunction

    // Applies one accepted item to the predictor and queues its answer.
    task automatic predict_item(logic [1:0] op, int pix, logic [DVAL_W-1:0] dval,
                                int sc, int sr);
        t_answer ans;
        int frame_size;
        frame_size = active_width() * active_height();
        ans.mask_bit = 1'b0;
        ans.pixel_count = '0;
        ans.status = ST_OK;
        case (op)
            OP_WRITE: begin
                if (pix < frame_size) depth_mem[pix] = dval;
                else ans.status = ST_RANGE;
            end
            OP_GROW: begin
                ans = flood_region(sc, sr);
            end
            OP_READ: begin
                if (pix < frame_size) ans.mask_bit = region_mask[pix];
                else ans.status = ST_RANGE;
            end
            default: return;
        endcase
        awaited_answers.insert(awaited_answers.size(), ans);
    endtask

    // Sends one item and keeps start high until the block takes it. The
    // sender may then idle for a random number of cycles.
    task automatic send_item(logic [1:0] op, int pix, logic [DVAL_W-1:0] dval,
                             int sc, int sr);
        i_op <= op;
        i_pixel_index <= IDX_W'(pix);
        i_depth_value <= dval;
        i_seed_col <= SEED_W'(sc);
        i_seed_row <= SEED_W'(sr);
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        predict_item(op, pix, dval, sc, sr);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
    endtask

    // Waits until every answer is in and the block is idle again. An unused
    // op gives no answer, so a short extra wait and a wait on busy cover any trailing work.
    task automatic wait_quiet();
        start <= 1'b0;
        while (awaited_answers.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] data);
        wait_quiet();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_WIDTH:  reg_width = data[CFG_W-1:0];
            CFG_HEIGHT: reg_height = data[CFG_W-1:0];
            CFG_THRESH: reg_thresh = data[THR_W-1:0];
            default: ;
        endcase
    endtask

    // A grow may only touch written depths, so the whole active frame is
    // loaded before any grow that can reach past its seed.
    task automatic load_frame(int base, int spread);
        int n;
        n = active_width() * active_height();
        for (int i = 0; i < n; i++)
            send_item(OP_WRITE, i, DVAL_W'(base + $urandom_range(0, spread)),
                      $urandom_range(0, 511), $urandom_range(0, 511));
    endtask

    // Out-of-frame indices, the last pixel of the default frame, an unused op
    // and both seed failure cases, all with the reset register values.
    task automatic test_default_frame();
        send_item(OP_WRITE, 0, 16'hFFFF, 0, 0);
        send_item(OP_WRITE, 512 * 424 - 1, 16'h0001, 511, 511);
        send_item(OP_WRITE, 512 * 424, 16'h1234, 0, 0);
        send_item(OP_READ, 262143, 16'hFFFF, 511, 511);
        send_item(OP_READ, 0, 16'h0000, 0, 0);
        send_item(OP_UNUSED, 262143, 16'hFFFF, 511, 511);
        // Seed row beyond the 424 active rows: the mask clears, nothing grows.
        send_item(OP_GROW, 0, 16'h0000, 511, 511);
        // A seed with no reading grows nothing either.
        send_item(OP_WRITE, 0, 16'h0000, 0, 0);
        send_item(OP_GROW, 0, 16'h0000, 0, 0);
        send_item(OP_READ, 0, 16'h0000, 0, 0);
    endtask

    // A small frame with a full read-back of the grown mask.
    task automatic test_small_frame();
        write_register(CFG_WIDTH, 16'd8);
        write_register(CFG_HEIGHT, 16'd6);
        write_register(CFG_THRESH, 16'd50);
        load_frame(2000, 120);
        send_item(OP_GROW, 0, 16'h0000, 3, 2);
        for (int i = 0; i < 8 * 6; i++) send_item(OP_READ, i, 16'h0000, 0, 0);
    endtask

    // Register extremes: a width that clamps to the maximum with a single
    // row and a zero threshold, then a zero width that acts as one column
    // with the largest threshold, where zero-depth pixels join as well.
    task automatic test_register_extremes();
        write_register(CFG_WIDTH, 16'd1023);
        write_register(CFG_HEIGHT, 16'd1);
        write_register(CFG_THRESH, 16'd0);
        // The third pixel differs by one, so the flood stops after two pixels
        // and never reads past the third.
        send_item(OP_WRITE, 0, 16'd100, 0, 0);
        send_item(OP_WRITE, 1, 16'd100, 0, 0);
        send_item(OP_WRITE, 2, 16'd101, 0, 0);
        send_item(OP_WRITE, 511, 16'd100, 0, 0);
        send_item(OP_GROW, 0, 16'h0000, 0, 0);
        send_item(OP_READ, 1, 16'h0000, 0, 0);
        send_item(OP_READ, 2, 16'h0000, 0, 0);
        send_item(OP_READ, 511, 16'h0000, 0, 0);
        send_item(OP_READ, 512, 16'h0000, 0, 0);
        write_register(CFG_WIDTH, 16'd0);
        write_register(CFG_HEIGHT, 16'd1023);
        write_register(CFG_THRESH, 16'hFFFF);
        load_frame(0, 65535);
        send_item(OP_WRITE, 3, 16'h0000, 0, 0);
        send_item(OP_WRITE, 7, 16'd7, 0, 0);
        send_item(OP_GROW, 0, 16'h0000, 0, 7);
        send_item(OP_READ, 3, 16'h0000, 0, 0);
        send_item(OP_READ, 511, 16'h0000, 0, 0);
    endtask

    // Random frame size and threshold, a loaded frame, then a random mix of
    // writes, reads, out-of-frame indices and unused ops around one grow.
    task automatic test_random_phase(int pct, int n_items);
        int w, h, thr, base, pick, frame_size;
        logic [DVAL_W-1:0] dval;
        idle_pct = pct;
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 8);
        thr = $urandom_range(0, 300);
        base = $urandom_range(1000, 60000);
        write_register(CFG_WIDTH, 16'(w));
        write_register(CFG_HEIGHT, 16'(h));
        write_register(CFG_THRESH, 16'(thr));
        frame_size = w * h;
        load_frame(base, 2 * thr + 20);
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0) dval = DVAL_W'($urandom());
            else dval = DVAL_W'(base + $urandom_range(0, 2 * thr + 20));
            if (i == n_items / 3)
                send_item(OP_GROW, $urandom_range(0, 262143), dval,
                          $urandom_range(0, w - 1), $urandom_range(0, h - 1));
            else if (pick < 40)
                send_item(OP_WRITE, $urandom_range(0, frame_size - 1), dval,
                          $urandom_range(0, 511), $urandom_range(0, 511));
            else if (pick < 78)
                send_item(OP_READ, $urandom_range(0, frame_size - 1), dval,
                          $urandom_range(0, 511), $urandom_range(0, 511));
            else if (pick < 95)
                send_item(($urandom_range(0, 1) == 0) ? OP_WRITE : OP_READ,
                          $urandom_range(0, 262143), dval,
                          $urandom_range(0, 511), $urandom_range(0, 511));
            else
                send_item(OP_UNUSED, $urandom_range(0, 262143), dval,
                          $urandom_range(0, 511), $urandom_range(0, 511));
        end
    endtask

    // Results cannot be held off, so each is checked in the cycle it shows.
    always @(posedge i_clk) begin
        t_answer ans;
        if (i_rst_n && o_done) begin
            if (awaited_answers.size() == 0) begin
                $error("result with no item awaiting it");
                fail_count++;
            end else begin
                ans = awaited_answers.pop_front();
                if (o_mask_bit !== ans.mask_bit) begin
                    $error("mask_bit expected %0d actual %0d", ans.mask_bit, o_mask_bit);
                    fail_count++;
                end
                if (o_pixel_count !== ans.pixel_count) begin
                    $error("pixel_count expected %0d actual %0d",
                           ans.pixel_count, o_pixel_count);
                    fail_count++;
                end
                if (o_status !== ans.status) begin
                    $error("status expected %0d actual %0d", ans.status, o_status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        start = 1'b0;
        i_op = OP_WRITE;
        i_pixel_index = '0;
        i_depth_value = '0;
        i_seed_col = '0;
        i_seed_row = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The directed part runs without sender gaps; the block still clears
        // its mask after reset, which send_item simply waits out.
        test_default_frame();
        test_small_frame();
        test_register_extremes();
        test_random_phase(36, 50);
        test_random_phase(74, 50);
        test_random_phase(0, 50);

        wait_quiet();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && awaited_answers.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

FILE: filelist.f
sv/drg_pkg.sv
sv/drg_ctrl.sv
sv/drg_dpath.sv
sv/depth_region_grow_top.sv
test/tb.sv
